### sv/bsrl_pkg.sv
// ----------------------------------------------------------------------------
// bsrl_pkg
// shared types and constants of the bounded sorted record list
// ----------------------------------------------------------------------------
package bsrl_pkg;

    localparam int KEY_WIDTH             = 32;
    localparam int DEPTH_DEFAULT         = 16;
    localparam int PAYLOAD_WIDTH_DEFAULT = 64;
    localparam int COUNT_WIDTH_DEFAULT   = $clog2(DEPTH_DEFAULT + 1);

    // operation codes of a request
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_FRONT  = 2'd1,
        OP_SORTED = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

endpackage

### sv/bsrl_req_if.sv
// ----------------------------------------------------------------------------
// bsrl_req_if
// request channel: one list operation with key and payload
// ----------------------------------------------------------------------------
interface bsrl_req_if #(
    parameter int PAYLOAD_WIDTH = bsrl_pkg::PAYLOAD_WIDTH_DEFAULT
);
    logic                                   valid;
    logic                                   ready;
    bsrl_pkg::op_t                          operation;
    logic signed [bsrl_pkg::KEY_WIDTH-1:0]  entry_key;
    logic [PAYLOAD_WIDTH-1:0]               entry_payload;

    modport source (
        output valid, operation, entry_key, entry_payload,
        input  ready
    );

    modport sink (
        input  valid, operation, entry_key, entry_payload,
        output ready
    );
endinterface

### sv/bsrl_rsp_if.sv
// ----------------------------------------------------------------------------
// bsrl_rsp_if
// result channel: status of an insert or one listed entry
// ----------------------------------------------------------------------------
interface bsrl_rsp_if #(
    parameter int PAYLOAD_WIDTH = bsrl_pkg::PAYLOAD_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH   = bsrl_pkg::COUNT_WIDTH_DEFAULT
);
    logic                                   valid;
    logic                                   ready;
    logic                                   accepted;
    logic [COUNT_WIDTH-1:0]                 entry_count;
    logic                                   is_full;
    logic                                   is_empty;
    logic                                   entry_valid;
    logic signed [bsrl_pkg::KEY_WIDTH-1:0]  out_key;
    logic [PAYLOAD_WIDTH-1:0]               out_payload;
    logic                                   last;

    modport source (
        output valid, accepted, entry_count, is_full, is_empty, entry_valid,
               out_key, out_payload, last,
        input  ready
    );

    modport sink (
        input  valid, accepted, entry_count, is_full, is_empty, entry_valid,
               out_key, out_payload, last,
        output ready
    );
endinterface

### sv/bsrl_store.sv
// ----------------------------------------------------------------------------
// bsrl_store
// record memory: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module bsrl_store #(
    parameter int DEPTH         = bsrl_pkg::DEPTH_DEFAULT,
    parameter int PAYLOAD_WIDTH = bsrl_pkg::PAYLOAD_WIDTH_DEFAULT,
    parameter int IDX_WIDTH     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [IDX_WIDTH-1:0]           waddr,
    input  logic [bsrl_pkg::KEY_WIDTH-1:0] wkey,
    input  logic [PAYLOAD_WIDTH-1:0]       wpayload,
    input  logic [IDX_WIDTH-1:0]           raddr,
    output logic [bsrl_pkg::KEY_WIDTH-1:0] rkey,
    output logic [PAYLOAD_WIDTH-1:0]       rpayload
);

    logic [bsrl_pkg::KEY_WIDTH-1:0] key_mem [DEPTH];
    logic [PAYLOAD_WIDTH-1:0]       pay_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wkey;
            pay_mem[waddr] <= wpayload;
        end
        rkey     <= key_mem[raddr];
        rpayload <= pay_mem[raddr];
    end

endmodule

### sv/bounded_sorted_record_list_unit.sv
// ----------------------------------------------------------------------------
// bounded_sorted_record_list_unit
// fixed-capacity record list with append, front insert, sorted insert, listing
// ----------------------------------------------------------------------------
// append or refused insert: append writes its record as the request is taken, then either
//   one gives its status; front insert moves the tail up, sorted insert first scans for the
//   slot and then moves the tail up one per cycle; on an empty list either one places the record at once
// listing: the first entry is read ahead, then one entry per cycle while the result side is ready;
//   all of this is set by the single read and single write port of the memory
// one request at a time, taken once all results left; reset clears the state and the count
// ----------------------------------------------------------------------------
module bounded_sorted_record_list_unit #(
    parameter int DEPTH         = bsrl_pkg::DEPTH_DEFAULT,
    parameter int PAYLOAD_WIDTH = bsrl_pkg::PAYLOAD_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    bsrl_req_if.sink    req,
    bsrl_rsp_if.source  rsp
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = bsrl_pkg::KEY_WIDTH;

    // one-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_LIST  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               acc_reg, acc_next;
    logic [KW-1:0]      key_reg, key_next;
    logic [PAYLOAD_WIDTH-1:0] pay_reg, pay_next;
    logic [IW-1:0]      pos_reg, pos_next;
    logic [IW-1:0]      scan_idx_reg, scan_idx_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]      sh_idx_reg, sh_idx_next;
    logic [CW-1:0]      remain_reg, remain_next;
    logic               wr_vld_reg, wr_vld_next;
    logic [IW-1:0]      wr_addr_reg, wr_addr_next;
    logic [IW-1:0]      list_idx_reg, list_idx_next;
    logic               primed_reg, primed_next;

    // memory port controls
    logic                     st_we;
    logic [IW-1:0]            st_waddr;
    logic [KW-1:0]            st_wkey;
    logic [PAYLOAD_WIDTH-1:0] st_wpayload;
    logic [IW-1:0]            st_raddr;
    logic [KW-1:0]            st_rkey;
    logic [PAYLOAD_WIDTH-1:0] st_rpayload;

    logic in_fire, out_fire, list_last, list_mode;

    bsrl_store #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .IDX_WIDTH     (IW)
    ) u_store (
        .clk      (clk),
        .we       (st_we),
        .waddr    (st_waddr),
        .wkey     (st_wkey),
        .wpayload (st_wpayload),
        .raddr    (st_raddr),
        .rkey     (st_rkey),
        .rpayload (st_rpayload)
    );

    // handshakes
    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign list_mode = (state_reg == S_LIST);
    assign rsp.valid = (state_reg == S_RESP) || (list_mode && primed_reg);
    assign out_fire  = rsp.valid && rsp.ready;
    assign list_last = ((CW'(list_idx_reg) + CW'(1)) == count_reg);

    // result fields: listed entry straight from the memory read register
    assign rsp.accepted    = list_mode ? 1'b0 : acc_reg;
    assign rsp.entry_count = count_reg;
    assign rsp.is_full     = (count_reg == CW'(DEPTH));
    assign rsp.is_empty    = (count_reg == '0);
    assign rsp.entry_valid = list_mode;
    assign rsp.out_key     = list_mode ? $signed(st_rkey) : '0;
    assign rsp.out_payload = list_mode ? st_rpayload : '0;
    assign rsp.last        = list_mode ? list_last : 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        acc_next      = acc_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        pos_next      = pos_reg;
        scan_idx_next = scan_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        sh_idx_next   = sh_idx_reg;
        remain_next   = remain_reg;
        wr_vld_next   = wr_vld_reg;
        wr_addr_next  = wr_addr_reg;
        list_idx_next = list_idx_reg;
        primed_next   = primed_reg;
        st_we         = 1'b0;
        st_waddr      = '0;
        st_wkey       = key_reg;
        st_wpayload   = pay_reg;
        st_raddr      = list_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    key_next    = req.entry_key;
                    pay_next    = req.entry_payload;
                    wr_vld_next = 1'b0;
                    if (req.operation == bsrl_pkg::OP_LIST)
                    begin
                        acc_next = 1'b0;
                        if (count_reg == '0)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            list_idx_next = '0;
                            primed_next   = 1'b0;
                            state_next    = S_LIST;
                        end
                    end
                    else if (count_reg == CW'(DEPTH))
                    begin
                        // full list refuses every insert
                        acc_next   = 1'b0;
                        state_next = S_RESP;
                    end
                    else if (req.operation == bsrl_pkg::OP_APPEND)
                    begin
                        st_we       = 1'b1;
                        st_waddr    = count_reg[IW-1:0];
                        st_wkey     = req.entry_key;
                        st_wpayload = req.entry_payload;
                        count_next  = count_reg + CW'(1);
                        acc_next    = 1'b1;
                        state_next  = S_RESP;
                    end
                    else if (req.operation == bsrl_pkg::OP_FRONT || count_reg == '0)
                    begin
                        pos_next    = '0;
                        sh_idx_next = IW'(count_reg - CW'(1));
                        remain_next = count_reg;
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        cmp_vld_next  = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // one read issued per cycle, compared in the cycle after
                st_raddr      = scan_idx_reg;
                scan_idx_next = scan_idx_reg + IW'(1);
                cmp_idx_next  = scan_idx_reg;
                cmp_vld_next  = 1'b1;
                sh_idx_next   = IW'(count_reg - CW'(1));
                if (cmp_vld_reg)
                begin
                    if (!($signed(st_rkey) < $signed(key_reg)))
                    begin
                        pos_next    = cmp_idx_reg;
                        remain_next = count_reg - CW'(cmp_idx_reg);
                        state_next  = S_SHIFT;
                    end
                    else if ((CW'(cmp_idx_reg) + CW'(1)) == count_reg)
                    begin
                        pos_next    = count_reg[IW-1:0];
                        remain_next = '0;
                        state_next  = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // move tail entries up one place, top entry first
                if (wr_vld_reg)
                begin
                    st_we       = 1'b1;
                    st_waddr    = wr_addr_reg;
                    st_wkey     = st_rkey;
                    st_wpayload = st_rpayload;
                end
                if (remain_reg != '0)
                begin
                    st_raddr     = sh_idx_reg;
                    wr_vld_next  = 1'b1;
                    wr_addr_next = sh_idx_reg + IW'(1);
                    sh_idx_next  = sh_idx_reg - IW'(1);
                    remain_next  = remain_reg - CW'(1);
                end
                else
                begin
                    wr_vld_next = 1'b0;
                    if (!wr_vld_reg)
                    begin
                        // slot open: place the new record
                        st_we      = 1'b1;
                        st_waddr   = pos_reg;
                        count_next = count_reg + CW'(1);
                        acc_next   = 1'b1;
                        state_next = S_RESP;
                    end
                end
            end

            S_LIST:
            begin
                // read ahead so that an entry can leave every cycle
                primed_next = 1'b1;
                if (out_fire)
                begin
                    st_raddr      = list_idx_reg + IW'(1);
                    list_idx_next = list_idx_reg + IW'(1);
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RESP:
            begin
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            acc_reg     <= 1'b0;
            cmp_vld_reg <= 1'b0;
            wr_vld_reg  <= 1'b0;
            primed_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            cmp_vld_reg <= cmp_vld_next;
            wr_vld_reg  <= wr_vld_next;
            primed_reg  <= primed_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        pos_reg      <= pos_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        sh_idx_reg   <= sh_idx_next;
        remain_reg   <= remain_next;
        wr_addr_reg  <= wr_addr_next;
        list_idx_reg <= list_idx_next;
    end

    // a result is never shown while a request can be taken
    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("result valid while request side is open");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    // writes never land beyond the stored region plus one
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> (CW'(st_waddr) <= count_reg))
        else $error("memory write outside the list");

    a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (list_mode && out_fire && rsp.last) |=> (state_reg == S_IDLE))
        else $error("listing did not end after its last entry");

    a_accept_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && acc_reg) |-> (count_reg != '0))
        else $error("accepted insert left the list empty");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bounded sorted record list: drives list
// operations with random idling and stalls, predicts every result and
// compares each one field by field
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = bsrl_pkg::DEPTH_DEFAULT;
    localparam int PAY_W       = bsrl_pkg::PAYLOAD_WIDTH_DEFAULT;
    localparam int CNT_W       = bsrl_pkg::COUNT_WIDTH_DEFAULT;
    localparam int KEY_W       = bsrl_pkg::KEY_WIDTH;
    localparam int RANDOM_REQS = 300;

    // one result as seen on the response channel
    typedef struct {
        logic                    accepted;
        logic [CNT_W-1:0]        entry_count;
        logic                    is_full;
        logic                    is_empty;
        logic                    entry_valid;
        logic signed [KEY_W-1:0] out_key;
        logic [PAY_W-1:0]        out_payload;
        logic                    last;
    } list_result_t;

    // ------------------------------------------------------------------------
    // list shadow and result checker
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic signed [KEY_W-1:0] shadow_keys[LIST_DEPTH];
        logic [PAY_W-1:0]        shadow_payloads[LIST_DEPTH];
        int unsigned             shadow_count;
        list_result_t            expected_results[$];
        int                      errors;
        int                      requests_seen;
        int                      results_checked;
        int                      listings_seen;
        int                      refused_seen;

        function new();
            shadow_count    = 0;
            errors          = 0;
            requests_seen   = 0;
            results_checked = 0;
            listings_seen   = 0;
            refused_seen    = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // status or entry result, with the counters taken from the shadow
        function void push_result(logic acc, logic ev, logic signed [KEY_W-1:0] k,
                                  logic [PAY_W-1:0] p, logic lst);
            list_result_t r;
            r.accepted    = acc;
            r.entry_count = CNT_W'(shadow_count);
            r.is_full     = (shadow_count == LIST_DEPTH);
            r.is_empty    = (shadow_count == 0);
            r.entry_valid = ev;
            r.out_key     = k;
            r.out_payload = p;
            r.last        = lst;
            expected_results.push_back(r);
        endfunction

        // works out the results that one accepted request causes
        function void note_request(bsrl_pkg::op_t op, logic signed [KEY_W-1:0] k,
                                   logic [PAY_W-1:0] p);
            int unsigned slot;
            requests_seen++;
            if (op == bsrl_pkg::OP_LIST)
            begin
                listings_seen++;
                if (shadow_count == 0)
                    push_result(1'b0, 1'b0, '0, '0, 1'b1);
                else
                    for (int unsigned i = 0; i < shadow_count; i++)
                        push_result(1'b0, 1'b1, shadow_keys[i], shadow_payloads[i],
                                    i + 1 == shadow_count);
                return;
            end
            if (shadow_count >= LIST_DEPTH)
            begin
                refused_seen++;
                push_result(1'b0, 1'b0, '0, '0, 1'b1);
                return;
            end
            case (op)
                bsrl_pkg::OP_APPEND: slot = shadow_count;
                bsrl_pkg::OP_FRONT:  slot = 0;
                default:
                begin
                    // stop at the first stored key that is not less than the new one
                    slot = 0;
                    while (slot < shadow_count && shadow_keys[slot] < k)
                        slot++;
                end
            endcase
            for (int unsigned i = shadow_count; i > slot; i--)
            begin
                shadow_keys[i]     = shadow_keys[i-1];
                shadow_payloads[i] = shadow_payloads[i-1];
            end
            shadow_keys[slot]     = k;
            shadow_payloads[slot] = p;
            shadow_count++;
            push_result(1'b1, 1'b0, '0, '0, 1'b1);
        endfunction

        function void compare_field(string name, logic [PAY_W-1:0] exp_v,
                                    logic [PAY_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: key %0h payload %0h",
                       got.out_key, got.out_payload);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            compare_field("accepted",    want.accepted,    got.accepted);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("is_full",     want.is_full,     got.is_full);
            compare_field("is_empty",    want.is_empty,    got.is_empty);
            compare_field("entry_valid", want.entry_valid, got.entry_valid);
            compare_field("out_key",     want.out_key,     got.out_key);
            compare_field("out_payload", want.out_payload, got.out_payload);
            compare_field("last",        want.last,        got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    bit   idle_on;      // random idling on both sides while set

    list_scoreboard sb = new();

    bsrl_req_if #(.PAYLOAD_WIDTH(PAY_W)) req_ch ();
    bsrl_rsp_if #(.PAYLOAD_WIDTH(PAY_W), .COUNT_WIDTH(CNT_W)) rsp_ch ();

    bounded_sorted_record_list_unit #(
        .DEPTH         (LIST_DEPTH),
        .PAYLOAD_WIDTH (PAY_W)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 12 ns period
    always #6 clk = ~clk;

    // result side: stall about 8 percent of the time while idling is on
    always @(negedge clk)
    begin
        rsp_ch.ready <= idle_on ? ($urandom_range(0, 99) >= 8) : 1'b1;
    end

    // sample both handshakes at the rising edge; results are checked before
    // a request of the same edge is noted, a request never answers itself
    always @(posedge clk)
    begin
        list_result_t got;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.accepted    = rsp_ch.accepted;
                got.entry_count = rsp_ch.entry_count;
                got.is_full     = rsp_ch.is_full;
                got.is_empty    = rsp_ch.is_empty;
                got.entry_valid = rsp_ch.entry_valid;
                got.out_key     = rsp_ch.out_key;
                got.out_payload = rsp_ch.out_payload;
                got.last        = rsp_ch.last;
                sb.check_result(got);
            end
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.operation, req_ch.entry_key, req_ch.entry_payload);
        end
    end

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------

    // valid stays high from one request to the next unless an idle gap falls
    // in between; the caller lowers it after the final request
    task automatic send_request(input bsrl_pkg::op_t op, input logic signed [KEY_W-1:0] k,
                                input logic [PAY_W-1:0] p);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < 8)
        begin
            gap = $urandom_range(1, 4);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.entry_key     <= k;
        req_ch.entry_payload <= p;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // hold the request side until every expected result has come back
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        bsrl_pkg::op_t           op;
        logic signed [KEY_W-1:0] k;
        logic [PAY_W-1:0]        p;
        int                      pick;

        clk                  = 1'b0;
        rst_n                = 1'b0;
        idle_on              = 1'b1;
        req_ch.valid         = 1'b0;
        req_ch.operation     = bsrl_pkg::OP_APPEND;
        req_ch.entry_key     = '0;
        req_ch.entry_payload = '0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty listing, every insert kind, key extremes, equal keys
        send_request(bsrl_pkg::OP_LIST,   32'sd0, '0);
        send_request(bsrl_pkg::OP_SORTED, 32'sd0, 64'h0123_4567_89ab_cdef);
        send_request(bsrl_pkg::OP_APPEND, 32'sh7fff_ffff, '1);
        send_request(bsrl_pkg::OP_FRONT,  32'sh8000_0000, '0);
        send_request(bsrl_pkg::OP_SORTED, -32'sd1, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(bsrl_pkg::OP_SORTED, 32'sd1, 64'h5555_5555_5555_5555);
        // equal keys land ahead of the stored twin
        send_request(bsrl_pkg::OP_SORTED, 32'sd0, 64'hfeed_0000_0000_0001);
        send_request(bsrl_pkg::OP_SORTED, 32'sh7fff_ffff, 64'h8000_0000_0000_0000);
        send_request(bsrl_pkg::OP_SORTED, 32'sh8000_0000, 64'h0000_0000_0000_0001);
        send_request(bsrl_pkg::OP_LIST,   32'sd0, '0);
        // a front insert and an append out of key order, then a sorted insert that lands at the front
        send_request(bsrl_pkg::OP_FRONT,  32'sh5555_5555, 64'hdead_beef_0000_0000);
        send_request(bsrl_pkg::OP_APPEND, -32'sd100, 64'h0000_0000_cafe_f00d);
        send_request(bsrl_pkg::OP_SORTED, 32'sd5, 64'h1111_2222_3333_4444);
        send_request(bsrl_pkg::OP_LIST,   32'sd0, '0);

        // pressure: sender holds off until the list side is quiet
        wait_drained();

        // random: the list fills early, after which inserts are refused and
        // listings walk the full list; a stretch in the middle runs without
        // any idling or stalls
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            idle_on = !(n >= 120 && n < 200);
            pick = $urandom_range(0, 99);
            if (pick < 20)
                op = bsrl_pkg::OP_LIST;
            else if (pick < 45)
                op = bsrl_pkg::OP_APPEND;
            else if (pick < 70)
                op = bsrl_pkg::OP_FRONT;
            else
                op = bsrl_pkg::OP_SORTED;
            // small keys now and then so that equal keys meet
            case ($urandom_range(0, 9))
                0:       k = 32'sh8000_0000;
                1:       k = 32'sh7fff_ffff;
                2, 3:    k = $signed(32'($urandom_range(0, 4)) - 32'd2);
                default: k = $signed($urandom);
            endcase
            p = {$urandom, $urandom};
            send_request(op, k, p);
            if (n % 64 == 63)
                wait_drained();
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        // room for any stray result behind the last expected one
        repeat (40) @(posedge clk);

        $display("covered %0d requests: %0d listings, %0d refused inserts",
                 sb.requests_seen, sb.listings_seen, sb.refused_seen);
        $display("%0d results compared, %0d mismatches", sb.results_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[bounded_sorted_record_list_unit] OK");
        else
            $display("[bounded_sorted_record_list_unit] ERROR");
        $finish;
    end

    // watchdog, far above the slowest correct run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("[bounded_sorted_record_list_unit] ERROR");
        $finish;
    end

endmodule

### sim.f
sv/bsrl_pkg.sv
sv/bsrl_req_if.sv
sv/bsrl_rsp_if.sv
sv/bsrl_store.sv
sv/bounded_sorted_record_list_unit.sv
tb/testbench.sv
